FILE: rtl/uss_pkg.sv
// Shared types and constants of the unique sorted sample set builder.
package uss_pkg;

  localparam int unsigned IdxW    = 64;
  localparam int unsigned SizeW   = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLower   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgUpper   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSetSize = 2'd2;

  localparam logic [SizeW-1:0] SetSizeReset = 5'd16;

  typedef enum logic [StatusW-1:0] {
    StAccepted  = 3'd0,
    StDuplicate = 3'd1,
    StMember    = 3'd2,
    StRealOut   = 3'd3,
    StTooFew    = 3'd4,
    StBadBounds = 3'd5,
    StDrawOut   = 3'd6,
    StIdle      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellShift  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [IdxW-1:0] cand;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StateRun  = 2'b01,
    StateEmit = 2'b10
  } state_e;

endpackage

FILE: rtl/uss_stream_if.sv
// Valid/ready channels for input items and result items.
interface uss_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [uss_pkg::IdxW-1:0] index_value;

  modport source (output valid, output mode, output index_value, input ready);
  modport sink   (input valid, input mode, input index_value, output ready);
endinterface

interface uss_out_if;
  logic                        valid;
  logic                        ready;
  logic [uss_pkg::StatusW-1:0] status;
  logic [uss_pkg::IdxW-1:0]    member_index;
  logic [uss_pkg::PosW-1:0]    position;
  logic                        is_real;
  logic                        last;

  modport source (output valid, output status, output member_index, output position,
                  output is_real, output last, input ready);
  modport sink   (input valid, input status, input member_index, input position,
                  input is_real, input last, output ready);
endinterface

FILE: rtl/uss_cell.sv
// One slot of the sorted member chain: compare, insert and shift.
module uss_cell (
  input  logic                     clk_i,
  input  uss_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     valid_i,
  input  logic [uss_pkg::IdxW-1:0] left_mem_i,
  input  logic                     left_lt_i,
  input  logic [uss_pkg::IdxW-1:0] right_mem_i,
  output logic [uss_pkg::IdxW-1:0] mem_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic [uss_pkg::IdxW-1:0] mem_q, mem_d;

  assign lt_o  = valid_i && (mem_q < ctrl_i.cand);
  assign eq_o  = valid_i && (mem_q == ctrl_i.cand);
  assign mem_o = mem_q;

  always_comb begin
    mem_d = mem_q;
    unique case (ctrl_i.op)
      uss_pkg::CellInsert: begin
        // cells below the candidate keep their value, the rest move up
        if (!lt_o) begin
          mem_d = left_lt_i ? ctrl_i.cand : left_mem_i;
        end
      end
      uss_pkg::CellShift: mem_d = right_mem_i;
      default:            mem_d = mem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mem_q <= mem_d;
  end

endmodule

FILE: rtl/unique_sorted_sample_set_builder.sv
// Top level of the unique sorted sample set builder.
// Usage: a start item (mode 0) carries the real index; it is checked against
// the bounds [lower_index, upper_index] and the set size, then seeds the set.
// Each draw item (mode 1) carries one random candidate: out of range is
// flagged, a duplicate is ignored, a new value is inserted in order.
// Channels: in_i (valid/ready, mode + index_value) and out_o (valid/ready,
// status, member_index, position, is_real, last). Config: cfg_we_i writes
// register cfg_idx_i (0 lower, 1 upper, 2 set size) with cfg_data_i.
// Timing: every item is decided in the cycle it is accepted; a result other than
// a set member sits in the output register from the next cycle. One item per cycle
// is taken while the receiver keeps up and no set is being emitted.
// When the set fills, members leave lowest first, one per cycle while the receiver
// keeps up, from the head of the cell chain; the input stays blocked until the last
// member is loaded.
// Insertion is a compare in every cell of the chain plus a shift of the cells from the insertion point up.
// Reset: no set in progress, bounds 0, set size 16, output empty.
// Stall: out_o holds its item; in_i.ready drops until the output frees up.
module unique_sorted_sample_set_builder #(
  parameter int unsigned SET_MAX = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  uss_in_if.sink                         in_i,
  uss_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [uss_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [uss_pkg::IdxW-1:0]       cfg_data_i
);

  localparam int unsigned CW = $clog2(SET_MAX + 1);

  // config registers
  logic [uss_pkg::IdxW-1:0]  lower_q, upper_q;
  logic [uss_pkg::SizeW-1:0] size_q;

  // control state
  uss_pkg::state_e          state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic                     coll_q, coll_d;
  logic [uss_pkg::IdxW-1:0] real_q, real_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  uss_pkg::status_e           out_status_q, out_status_d;
  logic [uss_pkg::IdxW-1:0]   out_member_q, out_member_d;
  logic [uss_pkg::PosW-1:0]   out_pos_q, out_pos_d;
  logic                       out_real_q, out_real_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load, out_free;

  // cell chain
  uss_pkg::cell_ctrl_t      ctrl;
  logic [uss_pkg::IdxW-1:0] mem   [SET_MAX];
  logic [SET_MAX-1:0]       lt, eq, valid;

  logic [CW-1:0]            want;
  logic [uss_pkg::IdxW-1:0] span;
  logic                     bad_bounds, v_out, too_few, dup, accept, in_ready;

  // ---------------- cells ----------------
  for (genvar k = 0; k < SET_MAX; k++) begin : g_cell
    logic [uss_pkg::IdxW-1:0] left_mem, right_mem;
    logic                     left_lt;

    // a start item sees an empty chain so the real index lands in cell 0
    assign valid[k] = (count_q > CW'(k)) && in_i.mode;

    if (k == 0) begin : g_head
      assign left_mem = '0;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_mem = mem[k-1];
      assign left_lt  = lt[k-1];
    end

    if (k == SET_MAX - 1) begin : g_tail
      assign right_mem = mem[k];
    end else begin : g_inner
      assign right_mem = mem[k+1];
    end

    uss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid[k]),
      .left_mem_i  (left_mem),
      .left_lt_i   (left_lt),
      .right_mem_i (right_mem),
      .mem_o       (mem[k]),
      .lt_o        (lt[k]),
      .eq_o        (eq[k])
    );
  end

  // ---------------- checks ----------------
  always_comb begin
    if (size_q == '0) begin
      want = CW'(1);
    end else if (32'(size_q) > 32'(SET_MAX)) begin
      want = CW'(SET_MAX);
    end else begin
      want = CW'(size_q);
    end
  end

  assign span       = upper_q - lower_q;
  assign bad_bounds = lower_q > upper_q;
  assign v_out      = (in_i.index_value < lower_q) || (in_i.index_value > upper_q);
  // range holds span+1 indices; compare without overflow
  assign too_few    = (uss_pkg::IdxW'(want) - uss_pkg::IdxW'(1)) > span;
  assign dup        = |eq;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == uss_pkg::StateRun) && out_free;
  assign accept   = in_i.valid && in_ready;

  // ---------------- main control ----------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    coll_d       = coll_q;
    real_d       = real_q;
    pos_d        = pos_q;
    ctrl.op      = uss_pkg::CellHold;
    ctrl.cand    = in_i.index_value;
    out_load     = 1'b0;
    out_status_d = uss_pkg::StAccepted;
    out_member_d = '0;
    out_pos_d    = '0;
    out_real_d   = 1'b0;
    out_last_d   = 1'b1;

    unique case (state_q)
      uss_pkg::StateRun: begin
        if (accept) begin
          if (!in_i.mode) begin
            priority if (bad_bounds) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StBadBounds;
              count_d      = '0;
              coll_d       = 1'b0;
            end else if (v_out) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StRealOut;
              count_d      = '0;
              coll_d       = 1'b0;
            end else if (too_few) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StTooFew;
              count_d      = '0;
              coll_d       = 1'b0;
            end else begin
              ctrl.op = uss_pkg::CellInsert;
              count_d = CW'(1);
              real_d  = in_i.index_value;
              coll_d  = 1'b1;
              if (want == CW'(1)) begin
                state_d = uss_pkg::StateEmit;
                pos_d   = '0;
              end else begin
                out_load     = 1'b1;
                out_status_d = uss_pkg::StAccepted;
              end
            end
          end else begin
            priority if (!coll_q) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StIdle;
            end else if (count_q >= want) begin
              // set size lowered mid-set: flush what is there
              state_d = uss_pkg::StateEmit;
              pos_d   = '0;
            end else if (v_out) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StDrawOut;
            end else if (dup) begin
              out_load     = 1'b1;
              out_status_d = uss_pkg::StDuplicate;
            end else begin
              ctrl.op = uss_pkg::CellInsert;
              count_d = CW'(count_q + CW'(1));
              if (CW'(count_q + CW'(1)) >= want) begin
                state_d = uss_pkg::StateEmit;
                pos_d   = '0;
              end else begin
                out_load     = 1'b1;
                out_status_d = uss_pkg::StAccepted;
              end
            end
          end
        end
      end
      uss_pkg::StateEmit: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = uss_pkg::StMember;
          out_member_d = mem[0];
          out_pos_d    = uss_pkg::PosW'(pos_q);
          out_real_d   = mem[0] == real_q;
          out_last_d   = pos_q == CW'(count_q - CW'(1));
          ctrl.op      = uss_pkg::CellShift;
          pos_d        = CW'(pos_q + CW'(1));
          if (out_last_d) begin
            state_d = uss_pkg::StateRun;
            coll_d  = 1'b0;
          end
        end
      end
      default: state_d = uss_pkg::StateRun;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q     <= '0;
      upper_q     <= '0;
      size_q      <= uss_pkg::SetSizeReset;
      state_q     <= uss_pkg::StateRun;
      count_q     <= '0;
      pos_q       <= '0;
      coll_q      <= 1'b0;
      real_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          uss_pkg::CfgLower:   lower_q <= cfg_data_i;
          uss_pkg::CfgUpper:   upper_q <= cfg_data_i;
          uss_pkg::CfgSetSize: size_q  <= cfg_data_i[uss_pkg::SizeW-1:0];
          default:             ;
        endcase
      end
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      coll_q      <= coll_d;
      real_q      <= real_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_member_q <= out_member_d;
      out_pos_q    <= out_pos_d;
      out_real_q   <= out_real_d;
      out_last_q   <= out_last_d;
    end
  end

  // ---------------- ports ----------------
  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.member_index = out_member_q;
  assign out_o.position     = out_pos_q;
  assign out_o.is_real      = out_real_q;
  assign out_o.last         = out_last_q;

endmodule

FILE: sim/sample_set_checker.sv
// Checker for the sample set builder: mirrors its set state and compares every result item.
module sample_set_checker #(
  parameter int unsigned SET_MAX = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  uss_in_if                           in_mon,
  uss_out_if                          out_mon,
  input  logic                        cfg_we_i,
  input  logic [uss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [uss_pkg::IdxW-1:0]    cfg_data_i,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);

  typedef struct packed {
    uss_pkg::status_e         status;
    logic [uss_pkg::IdxW-1:0] member_index;
    logic [uss_pkg::PosW-1:0] position;
    logic                     is_real;
    logic                     last;
  } set_result_t;

  logic [uss_pkg::IdxW-1:0]  lower_bound = '0;
  logic [uss_pkg::IdxW-1:0]  upper_bound = '0;
  logic [uss_pkg::SizeW-1:0] size_reg    = uss_pkg::SetSizeReset;
  logic [uss_pkg::IdxW-1:0]  members [SET_MAX];
  int unsigned               member_cnt  = 0;
  logic [uss_pkg::IdxW-1:0]  real_idx    = '0;
  bit                        collecting  = 1'b0;
  set_result_t               set_results [$];
  int unsigned               err_cnt     = 0;

  assign errors_o = err_cnt;

  function automatic int unsigned target_size();
    int unsigned s;
    s = size_reg;
    if (s == 0) s = 1;
    if (s > SET_MAX) s = SET_MAX;
    return s;
  endfunction

  function automatic void push_single(uss_pkg::status_e st);
    set_result_t r;
    r.status       = st;
    r.member_index = '0;
    r.position     = '0;
    r.is_real      = 1'b0;
    r.last         = 1'b1;
    set_results.push_back(r);
  endfunction

  // rejected start: any open set is dropped
  function automatic void reject_start(uss_pkg::status_e st);
    collecting = 1'b0;
    member_cnt = 0;
    push_single(st);
  endfunction

  // full set leaves lowest first
  function automatic void push_members();
    set_result_t r;
    int unsigned n;
    int unsigned k;
    n = (member_cnt > SET_MAX) ? SET_MAX : member_cnt;
    for (k = 0; k < n; k++) begin
      r.status       = uss_pkg::StMember;
      r.member_index = members[k];
      r.position     = uss_pkg::PosW'(k);
      r.is_real      = (members[k] == real_idx);
      r.last         = (k + 1 == n);
      set_results.push_back(r);
    end
    collecting = 1'b0;
  endfunction

  function automatic void build_set_step(logic draw, logic [uss_pkg::IdxW-1:0] v);
    int unsigned want;
    int unsigned pos;
    int unsigned k;
    want = target_size();
    if (!draw) begin
      if (lower_bound > upper_bound) begin
        reject_start(uss_pkg::StBadBounds);
      end else if (v < lower_bound || v > upper_bound) begin
        reject_start(uss_pkg::StRealOut);
      end else if (uss_pkg::IdxW'(want - 1) > upper_bound - lower_bound) begin
        reject_start(uss_pkg::StTooFew);
      end else begin
        real_idx   = v;
        members[0] = v;
        member_cnt = 1;
        collecting = 1'b1;
        if (member_cnt >= want) push_members();
        else push_single(uss_pkg::StAccepted);
      end
    end else if (!collecting) begin
      push_single(uss_pkg::StIdle);
    end else if (member_cnt >= want) begin
      // size lowered under an open set: emit it, candidate dropped
      push_members();
    end else if (v < lower_bound || v > upper_bound) begin
      push_single(uss_pkg::StDrawOut);
    end else begin
      pos = 0;
      while (pos < member_cnt && members[pos] < v) pos++;
      if (pos < member_cnt && members[pos] == v) begin
        push_single(uss_pkg::StDuplicate);
      end else begin
        for (k = member_cnt; k > pos; k--) members[k] = members[k - 1];
        members[pos] = v;
        member_cnt++;
        if (member_cnt >= want) push_members();
        else push_single(uss_pkg::StAccepted);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t got;
    set_result_t exp_r;
    if (!rst_ni) begin
      lower_bound = '0;
      upper_bound = '0;
      size_reg    = uss_pkg::SetSizeReset;
      member_cnt  = 0;
      real_idx    = '0;
      collecting  = 1'b0;
      set_results.delete();
      pending_o  <= 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.status       = uss_pkg::status_e'(out_mon.status);
        got.member_index = out_mon.member_index;
        got.position     = out_mon.position;
        got.is_real      = out_mon.is_real;
        got.last         = out_mon.last;
        if (set_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: status %0d index %h pos %0d real %0b last %0b",
                     got.status, got.member_index, got.position, got.is_real, got.last);
        end else begin
          exp_r = set_results.pop_front();
          if (got !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: exp status %0d index %h pos %0d real %0b last %0b",
                       exp_r.status, exp_r.member_index, exp_r.position, exp_r.is_real,
                       exp_r.last);
              $display("          got status %0d index %h pos %0d real %0b last %0b",
                       got.status, got.member_index, got.position, got.is_real, got.last);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) build_set_step(in_mon.mode, in_mon.index_value);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uss_pkg::CfgLower:   lower_bound = cfg_data_i;
          uss_pkg::CfgUpper:   upper_bound = cfg_data_i;
          uss_pkg::CfgSetSize: size_reg    = cfg_data_i[uss_pkg::SizeW-1:0];
          default: ;
        endcase
      end
      pending_o <= set_results.size();
    end
  end

endmodule

FILE: sim/unique_sorted_sample_set_builder_tb.sv
// Stimulus and verdict for the unique sorted sample set builder.
module unique_sorted_sample_set_builder_tb;

  localparam int unsigned              SetMax     = 16;
  localparam logic                     ModeStart  = 1'b0;
  localparam logic                     ModeDraw   = 1'b1;
  localparam logic [uss_pkg::IdxW-1:0] IdxMax     = '1;
  localparam int unsigned              NumItems   = 450;
  localparam int unsigned              CalmItems  = 80;   // tail of the run with no idling
  localparam int unsigned              HoldCycles = 120;  // long receiver stall, fills the block

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [uss_pkg::CfgIdxW-1:0] cfg_idx;
  logic [uss_pkg::IdxW-1:0]    cfg_data;
  int unsigned                 pending;
  int unsigned                 errors;

  // knobs shared by the sender and the receiver, and the sender's item count
  bit                 idle_on;
  bit                 hold_req;
  int unsigned        items_sent;

  uss_in_if  in_if ();
  uss_out_if out_if ();

  unique_sorted_sample_set_builder #(
    .SET_MAX (SetMax)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sample_set_checker #(
    .SET_MAX (SetMax)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always #5 clk = ~clk;

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [uss_pkg::IdxW-1:0] rand_index();
    return {$urandom(), $urandom()};
  endfunction

  // Bounds sit on the edges one time in four.
  function automatic logic [uss_pkg::IdxW-1:0] pick_in(logic [uss_pkg::IdxW-1:0] lo,
                                                       logic [uss_pkg::IdxW-1:0] hi);
    logic [uss_pkg::IdxW-1:0] span;
    span = hi - lo;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: begin
        if (span == IdxMax) return rand_index();
        return lo + rand_index() % (span + 1);
      end
    endcase
  endfunction

  // Falls back to an in-range value when the bounds cover the whole index space.
  function automatic logic [uss_pkg::IdxW-1:0] pick_outside(logic [uss_pkg::IdxW-1:0] lo,
                                                            logic [uss_pkg::IdxW-1:0] hi);
    bit below;
    below = (lo != '0) && (hi == IdxMax || $urandom_range(0, 1) == 1);
    if (below) return ($urandom_range(0, 1) == 1) ? lo - 1 : rand_index() % lo;
    if (hi != IdxMax)
      return ($urandom_range(0, 1) == 1) ? hi + 1 : hi + 1 + rand_index() % (IdxMax - hi);
    return pick_in(lo, hi);
  endfunction

  // Size field as the block reads it: 0 means 1, anything past SetMax is clipped.
  function automatic int unsigned members_wanted(logic [uss_pkg::SizeW-1:0] sz);
    if (sz == 0) return 1;
    if (sz > SetMax) return SetMax;
    return sz;
  endfunction

  // One item per call; valid stays up through stalls until the handshake.
  task automatic send_item(logic mode, logic [uss_pkg::IdxW-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.index_value <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Every item yields at least one result, so an empty scoreboard means the block is idle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // All three registers on back-to-back cycles, write enable held high throughout.
  task automatic load_config(logic [uss_pkg::IdxW-1:0] lo, logic [uss_pkg::IdxW-1:0] hi,
                             logic [uss_pkg::IdxW-1:0] size_word);
    cfg_we   <= 1'b1;
    cfg_idx  <= uss_pkg::CfgLower;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= uss_pkg::CfgUpper;
    cfg_data <= hi;
    @(posedge clk);
    cfg_idx  <= uss_pkg::CfgSetSize;
    cfg_data <= size_word;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One start plus draws until the set should be full. The local list of drawn values
  // only steers the stimulus; all checking lives in the checker.
  task automatic run_set(logic [uss_pkg::IdxW-1:0] lo, logic [uss_pkg::IdxW-1:0] hi,
                         int unsigned want);
    logic [uss_pkg::IdxW-1:0] real_v;
    logic [uss_pkg::IdxW-1:0] cand;
    logic [uss_pkg::IdxW-1:0] drawn [$];
    bit                       fresh;
    int unsigned              pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) real_v = pick_outside(lo, hi);
    else real_v = pick_in(lo, hi);
    send_item(ModeStart, real_v);
    if (lo > hi || real_v < lo || real_v > hi || uss_pkg::IdxW'(want - 1) > hi - lo) begin
      // start refused: a trailing draw finds no open set
      if ($urandom_range(0, 1) == 1) send_item(ModeDraw, pick_in(lo, hi));
      return;
    end
    drawn.push_back(real_v);
    while (drawn.size() < want) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        // restart mid-set: the open set is thrown away
        cand = pick_in(lo, hi);
        send_item(ModeStart, cand);
        drawn.delete();
        drawn.push_back(cand);
        continue;
      end
      if (pick < 5) cand = pick_outside(lo, hi);
      else if (pick < 11) cand = drawn[$urandom_range(0, drawn.size() - 1)];
      else cand = pick_in(lo, hi);
      send_item(ModeDraw, cand);
      fresh = (cand >= lo && cand <= hi);
      foreach (drawn[k]) if (drawn[k] == cand) fresh = 1'b0;
      if (fresh) drawn.push_back(cand);
    end
    // stray draw after the set went out
    if ($urandom_range(0, 9) == 0) send_item(ModeDraw, rand_index());
  endtask

  // One configuration, then sets until the item budget is spent.
  task automatic run_phase(int unsigned budget);
    logic [uss_pkg::IdxW-1:0]  lo;
    logic [uss_pkg::IdxW-1:0]  hi;
    logic [uss_pkg::IdxW-1:0]  size_word;
    logic [uss_pkg::SizeW-1:0] sz;
    int unsigned               want;
    int unsigned               stop_at;
    case ($urandom_range(0, 9))
      0:       sz = 5'd16;
      1:       sz = 5'd0;
      2:       sz = uss_pkg::SizeW'($urandom_range(17, 31));
      default: sz = uss_pkg::SizeW'($urandom_range(1, 6));
    endcase
    want = members_wanted(sz);
    case ($urandom_range(0, 9))
      0: begin  // whole index space
        lo = '0;
        hi = IdxMax;
      end
      1: begin  // hard against the top
        hi = IdxMax;
        lo = IdxMax - uss_pkg::IdxW'($urandom_range(0, 40));
      end
      2: begin  // inverted
        hi = rand_index() >> 1;
        lo = hi + 1 + uss_pkg::IdxW'($urandom_range(0, 50));
      end
      3: begin  // one index short of the set size
        lo = rand_index() >> 1;
        hi = lo + uss_pkg::IdxW'(want) - ((want > 1) ? 2 : 1);
      end
      4: begin  // exact fit
        lo = rand_index() >> 1;
        hi = lo + uss_pkg::IdxW'(want - 1);
      end
      5: begin  // from zero
        lo = '0;
        hi = uss_pkg::IdxW'(want - 1 + $urandom_range(0, 30));
      end
      6: begin  // wide span
        lo = rand_index() >> 1;
        hi = lo + (rand_index() >> 2);
      end
      default: begin  // narrow span, duplicates frequent
        lo = rand_index() >> 1;
        hi = lo + uss_pkg::IdxW'(want - 1 + $urandom_range(0, 40));
      end
    endcase
    // upper bits of the size word are don't-care; exercise them
    size_word = ($urandom_range(0, 1) == 1) ? rand_index() : '0;
    size_word[uss_pkg::SizeW-1:0] = sz;
    load_config(lo, hi, size_word);
    stop_at = items_sent + budget;
    if (lo > hi || uss_pkg::IdxW'(want - 1) > hi - lo) stop_at = items_sent + 4;
    while (items_sent < stop_at) run_set(lo, hi, want);
    wait_drained();
  endtask

  // Receiver: random stall bursts, long ready stretches, and one long hold-off on request.
  initial begin
    int unsigned burst;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        burst = $urandom_range(1, 11);
        repeat (burst) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        burst = idle_on ? $urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 12) : 1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed cases, random phases, then the verdict.
  initial begin
    int unsigned phase;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= uss_pkg::CfgLower;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.mode        <= ModeStart;
    in_if.index_value <= '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: no open set, bounds [0,0], size 16.
    send_item(ModeDraw, IdxMax);          // draw with no open set
    send_item(ModeStart, '0);             // one index, sixteen wanted: too few
    wait_drained();

    // Inverted bounds win over the real range check.
    load_config(64'd10, 64'd5, 64'd4);
    send_item(ModeStart, 64'd7);
    wait_drained();

    // Size 0 acts as 1: the start emits its lone member at once.
    load_config('0, IdxMax, '0);
    send_item(ModeStart, IdxMax);
    send_item(ModeDraw, 64'd1);           // set already closed
    wait_drained();

    // Range [100,200], four members.
    load_config(64'd100, 64'd200, 64'd4);
    send_item(ModeStart, 64'd99);         // real below range
    send_item(ModeStart, 64'd201);        // real above range
    send_item(ModeStart, 64'd150);
    send_item(ModeDraw, 64'd150);         // duplicate of the real index
    send_item(ModeDraw, 64'd99);          // draw below range
    send_item(ModeDraw, 64'd201);         // draw above range
    send_item(ModeDraw, 64'd100);
    send_item(ModeStart, 64'd120);        // restart drops 150 and 100
    send_item(ModeDraw, 64'd200);
    send_item(ModeDraw, 64'd100);
    send_item(ModeDraw, 64'd130);         // fourth member fills the set
    wait_drained();

    // Three indices: four is too many, three is an exact fit.
    load_config('0, 64'd2, 64'd4);
    send_item(ModeStart, 64'd1);
    wait_drained();
    load_config('0, 64'd2, 64'd3);
    send_item(ModeStart, 64'd1);
    wait_drained();
    load_config('0, 64'd2, 64'd2);        // shrink under the open set
    send_item(ModeDraw, '0);
    wait_drained();

    // Set grows to three, then the size drops below the count.
    load_config('0, IdxMax, 64'd5);
    send_item(ModeStart, 64'h8000_0000_0000_0000);
    send_item(ModeDraw, '0);
    send_item(ModeDraw, IdxMax);
    wait_drained();
    load_config('0, IdxMax, 64'd2);
    send_item(ModeDraw, 64'd5);           // emits all three, candidate dropped
    send_item(ModeStart, 64'd7);
    wait_drained();

    // Upper bound moved under the open set: draws see the new one.
    load_config('0, 64'd6, 64'd2);
    send_item(ModeDraw, 64'd8);
    send_item(ModeDraw, 64'd3);
    wait_drained();

    // Random phases; one early phase runs into the long receiver hold-off.
    items_sent = 0;
    phase      = 0;
    while (items_sent < NumItems) begin
      if (phase == 2) hold_req = 1'b1;
      if (items_sent + CalmItems > NumItems) idle_on = 1'b0;
      run_phase($urandom_range(15, 50));
      phase++;
    end

    // Room for any stray result to show up.
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: unique_sorted_sample_set_builder.f
rtl/uss_pkg.sv
rtl/uss_stream_if.sv
rtl/uss_cell.sv
rtl/unique_sorted_sample_set_builder.sv
sim/sample_set_checker.sv
sim/unique_sorted_sample_set_builder_tb.sv
